@@ design/sfps_pkg.sv @@
package sfps_pkg;

    // Fixed shape of one observation
    localparam int MIC_COUNT = 4;
    localparam int LEVEL_W   = 16;
    localparam int FACE_W    = 10;
    localparam int CAMW_W    = 11;
    localparam int BYTE_W    = 8;
    localparam int POS_W     = 16;

    // Job queue between the classifier and the move engine
    localparam int QUEUE_DEPTH = 2;

    // Face divide retires two quotient bits per cycle
    localparam int DIV_STEPS = FACE_W / 2;

    localparam logic [CAMW_W-1:0] CAMERA_WIDTH_RESET = 11'd640;

    // Configuration register indexes
    localparam logic REG_CAMERA_WIDTH   = 1'b0;
    localparam logic REG_ROTATOR_ENABLE = 1'b1;

    typedef enum logic [1:0] {
        SECTOR_A = 2'd0,
        SECTOR_B = 2'd1,
        SECTOR_C = 2'd2
    } sector_t;

    typedef enum logic [1:0] {
        ORIGIN_SECTOR = 2'd0,
        ORIGIN_FACE   = 2'd1,
        ORIGIN_HOME   = 2'd2
    } origin_t;

    // One classified word handed from the front to the back
    typedef struct packed {
        logic              home;
        logic              change;
        sector_t           from_sec;
        sector_t           to_sec;
        logic [FACE_W-1:0] face;
    } job_t;

    typedef struct packed {
        logic [CAMW_W-1:0] camera_width;
        logic              rotator_enable;
    } cfg_t;

endpackage

@@ design/sfps_queue.sv @@
module sfps_queue #(
    parameter int DEPTH = sfps_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sfps_pkg::job_t  push_job,
    output logic            full,
    input  logic            pop,
    output sfps_pkg::job_t  pop_job,
    output logic            empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sfps_pkg::job_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push_ok, pop_ok;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;
    assign pop_job = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push_ok, pop_ok})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold queued words
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ design/sfps_front.sv @@
module sfps_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          command,
    input  logic [sfps_pkg::LEVEL_W-1:0]  level_mic0,
    input  logic [sfps_pkg::LEVEL_W-1:0]  level_mic1,
    input  logic [sfps_pkg::LEVEL_W-1:0]  level_mic2,
    input  logic [sfps_pkg::LEVEL_W-1:0]  level_mic3,
    input  logic [sfps_pkg::FACE_W-1:0]   face_column,
    input  logic                          q_full,
    output logic                          q_push,
    output sfps_pkg::job_t                q_job
);

    typedef enum logic [1:0] {
        F_IDLE,
        F_SORT1,
        F_SORT2,
        F_PUSH
    } state_t;

    state_t state_reg, state_next;

    // Sort slots carry a level together with its microphone number
    logic [sfps_pkg::MIC_COUNT-1:0][sfps_pkg::LEVEL_W-1:0] slot_lv_reg, slot_lv_next;
    logic [sfps_pkg::MIC_COUNT-1:0][1:0]                   slot_ix_reg, slot_ix_next;
    logic                                                  home_reg, home_next;
    logic [sfps_pkg::FACE_W-1:0]                           face_reg, face_next;
    sfps_pkg::sector_t                                     sector_reg, sector_next;

    logic              silent;
    logic [1:0]        lo_ix, hi_ix;
    sfps_pkg::sector_t new_sector;

    assign in_stall = (state_reg != F_IDLE);

    // Pick the sector from the two loudest microphones
    assign silent = (slot_lv_reg[0] == '0);
    assign lo_ix  = (slot_ix_reg[0] < slot_ix_reg[1]) ? slot_ix_reg[0] : slot_ix_reg[1];
    assign hi_ix  = (slot_ix_reg[0] < slot_ix_reg[1]) ? slot_ix_reg[1] : slot_ix_reg[0];

    always_comb
    begin
        priority if (lo_ix == 2'd0 && hi_ix == 2'd1)
        begin
            new_sector = sfps_pkg::SECTOR_A;
        end
        else if (lo_ix == 2'd1 && hi_ix == 2'd2)
        begin
            new_sector = sfps_pkg::SECTOR_B;
        end
        else if (lo_ix == 2'd2 && hi_ix == 2'd3)
        begin
            new_sector = sfps_pkg::SECTOR_C;
        end
        else
        begin
            new_sector = sector_reg;
        end
    end

    // Build the outgoing word
    always_comb
    begin
        q_job.home     = home_reg;
        q_job.change   = !home_reg && (new_sector != sector_reg);
        q_job.from_sec = sector_reg;
        q_job.to_sec   = home_reg ? sector_reg : new_sector;
        q_job.face     = face_reg;
    end

    assign q_push = (state_reg == F_PUSH) && !q_full && (home_reg || !silent);

    // Exchange sort: compare-swap pairs in the order of the nested scan,
    // a swap only when the earlier slot is strictly quieter
    always_comb
    begin
        state_next   = state_reg;
        slot_lv_next = slot_lv_reg;
        slot_ix_next = slot_ix_reg;
        home_next    = home_reg;
        face_next    = face_reg;
        sector_next  = sector_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    slot_lv_next = {level_mic3, level_mic2, level_mic1, level_mic0};
                    slot_ix_next = {2'd3, 2'd2, 2'd1, 2'd0};
                    home_next    = command;
                    face_next    = face_column;
                    state_next   = command ? F_PUSH : F_SORT1;
                end
            end
            F_SORT1:
            begin
                if (slot_lv_next[0] < slot_lv_next[1])
                begin
                    {slot_lv_next[0], slot_lv_next[1]} = {slot_lv_next[1], slot_lv_next[0]};
                    {slot_ix_next[0], slot_ix_next[1]} = {slot_ix_next[1], slot_ix_next[0]};
                end
                if (slot_lv_next[0] < slot_lv_next[2])
                begin
                    {slot_lv_next[0], slot_lv_next[2]} = {slot_lv_next[2], slot_lv_next[0]};
                    {slot_ix_next[0], slot_ix_next[2]} = {slot_ix_next[2], slot_ix_next[0]};
                end
                state_next = F_SORT2;
            end
            F_SORT2:
            begin
                if (slot_lv_next[0] < slot_lv_next[3])
                begin
                    {slot_lv_next[0], slot_lv_next[3]} = {slot_lv_next[3], slot_lv_next[0]};
                    {slot_ix_next[0], slot_ix_next[3]} = {slot_ix_next[3], slot_ix_next[0]};
                end
                if (slot_lv_next[1] < slot_lv_next[2])
                begin
                    {slot_lv_next[1], slot_lv_next[2]} = {slot_lv_next[2], slot_lv_next[1]};
                    {slot_ix_next[1], slot_ix_next[2]} = {slot_ix_next[2], slot_ix_next[1]};
                end
                if (slot_lv_next[1] < slot_lv_next[3])
                begin
                    {slot_lv_next[1], slot_lv_next[3]} = {slot_lv_next[3], slot_lv_next[1]};
                    {slot_ix_next[1], slot_ix_next[3]} = {slot_ix_next[3], slot_ix_next[1]};
                end
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                // Drop silent observations, otherwise wait for queue room
                if (!home_reg && silent)
                begin
                    state_next = F_IDLE;
                end
                else if (!q_full)
                begin
                    if (!home_reg)
                    begin
                        sector_next = new_sector;
                    end
                    state_next = F_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            sector_reg <= sfps_pkg::SECTOR_B;
        end
        else
        begin
            state_reg  <= state_next;
            sector_reg <= sector_next;
        end
    end

    // Hold the captured word
    always_ff @(posedge clk)
    begin
        slot_lv_reg <= slot_lv_next;
        slot_ix_reg <= slot_ix_next;
        home_reg    <= home_next;
        face_reg    <= face_next;
    end

endmodule

@@ design/sfps_back.sv @@
module sfps_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sfps_pkg::cfg_t                    cfg,
    input  logic                              q_empty,
    input  sfps_pkg::job_t                    q_job,
    output logic                              q_pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [sfps_pkg::BYTE_W-1:0]       step_byte,
    output logic [1:0]                        move_origin,
    output logic signed [sfps_pkg::POS_W-1:0] position_after,
    output logic                              last
);

    localparam int FW = sfps_pkg::FACE_W;
    localparam int BW = sfps_pkg::BYTE_W;
    localparam int PW = sfps_pkg::POS_W;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SECT,
        B_DIV,
        B_FACE,
        B_EMIT_SEC,
        B_EMIT_FACE,
        B_EMIT_HOME
    } state_t;

    state_t                state_reg, state_next;
    sfps_pkg::job_t        job_reg, job_next;
    logic signed [PW-1:0]  pos_reg, pos_next;
    logic [BW-1:0]         sec_byte_reg, sec_byte_next;
    logic                  sec_pend_reg, sec_pend_next;
    logic [BW-1:0]         face_byte_reg, face_byte_next;
    logic                  face_pend_reg, face_pend_next;
    logic                  above_reg, above_next;
    logic [FW-1:0]         quo_reg, quo_next;
    logic [5:0]            rem_reg, rem_next;
    logic [2:0]            cnt_reg, cnt_next;
    logic                  out_valid_reg, out_valid_next;
    logic [BW-1:0]         out_byte_reg, out_byte_next;
    sfps_pkg::origin_t     out_origin_reg, out_origin_next;
    logic signed [PW-1:0]  out_pos_reg, out_pos_next;
    logic                  out_last_reg, out_last_next;

    logic                  out_free;
    logic [15:0]           pps_prod;
    logic [5:0]            pps_raw, pps;
    logic [FW-1:0]         half;
    logic                  face_above;
    logic [FW-1:0]         dividend;
    logic [6:0]            div_r1, div_r1s, div_r2, div_r2s;
    logic                  div_ge1, div_ge2;
    logic [FW-1:0]         div_q1, div_q2;
    logic [BW-1:0]         sec_byte_w, home_byte_w, face_byte_w;
    logic                  face_dead;
    logic signed [PW-1:0]  pos_after_sec, pos_after_face;

    // Step position update, saturating to the 16-bit range
    function automatic logic signed [PW-1:0] apply_move(
        input logic signed [PW-1:0] p,
        input logic [BW-1:0]        b
    );
        logic [BW:0]          mag;
        logic signed [PW:0]   s;
        if (b > 8'd128)
        begin
            mag = {1'b0, b} - 9'd127;
            s   = $signed({p[PW-1], p}) - $signed({8'd0, mag});
        end
        else
        begin
            mag = {1'b0, b} + 9'd1;
            s   = $signed({p[PW-1], p}) + $signed({8'd0, mag});
        end
        if (s[PW] != s[PW-1])
        begin
            apply_move = s[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
        end
        else
        begin
            apply_move = s[PW-1:0];
        end
    endfunction

    // Sector change table, taken modulo 256
    function automatic logic [BW-1:0] sector_byte(
        input sfps_pkg::sector_t    from_sec,
        input sfps_pkg::sector_t    to_sec,
        input logic signed [PW-1:0] p
    );
        logic [BW-1:0] pl;
        pl = p[BW-1:0];
        priority if (from_sec == sfps_pkg::SECTOR_A && to_sec == sfps_pkg::SECTOR_B)
        begin
            sector_byte = 8'd128 + pl;
        end
        else if (from_sec == sfps_pkg::SECTOR_A && to_sec == sfps_pkg::SECTOR_C)
        begin
            sector_byte = (p >= 16'sd40) ? 8'd168 + pl : 8'd248 - pl;
        end
        else if (from_sec == sfps_pkg::SECTOR_B && to_sec == sfps_pkg::SECTOR_A)
        begin
            sector_byte = 8'd40 - pl;
        end
        else if (from_sec == sfps_pkg::SECTOR_B && to_sec == sfps_pkg::SECTOR_C)
        begin
            sector_byte = 8'd168 + pl;
        end
        else if (from_sec == sfps_pkg::SECTOR_C && to_sec == sfps_pkg::SECTOR_A)
        begin
            sector_byte = 8'd40 - pl;
        end
        else if (from_sec == sfps_pkg::SECTOR_C && to_sec == sfps_pkg::SECTOR_B)
        begin
            sector_byte = 8'd0 - pl;
        end
        else
        begin
            sector_byte = '0;
        end
    endfunction

    assign out_free = !out_valid_reg || !out_stall;

    // Pixels per step: width/40 as (width>>3)*205>>10, never below one
    assign pps_prod = {8'd0, cfg.camera_width[10:3]} * 16'd205;
    assign pps_raw  = pps_prod[15:10];
    assign pps      = (pps_raw == '0) ? 6'd1 : pps_raw;
    assign half     = cfg.camera_width[10:1];

    assign face_above = (job_reg.face > half);
    assign dividend   = face_above ? job_reg.face - half : half - job_reg.face;

    // Two restoring divide steps
    assign div_r1  = {rem_reg, quo_reg[FW-1]};
    assign div_ge1 = (div_r1 >= {1'b0, pps});
    assign div_r1s = div_ge1 ? div_r1 - {1'b0, pps} : div_r1;
    assign div_q1  = {quo_reg[FW-2:0], div_ge1};
    assign div_r2  = {div_r1s[5:0], div_q1[FW-1]};
    assign div_ge2 = (div_r2 >= {1'b0, pps});
    assign div_r2s = div_ge2 ? div_r2 - {1'b0, pps} : div_r2;
    assign div_q2  = {div_q1[FW-2:0], div_ge2};

    assign sec_byte_w  = sector_byte(job_reg.from_sec, job_reg.to_sec, pos_reg);
    assign home_byte_w = (pos_reg > 16'sd0) ? pos_reg[BW-1:0] + 8'd127 : ~pos_reg[BW-1:0];
    assign face_byte_w = above_reg ? quo_reg[BW-1:0] : 8'd128 + quo_reg[BW-1:0];
    assign face_dead   = (face_byte_w < 8'd2) || (face_byte_w == 8'd128)
                         || (face_byte_w == 8'd129);
    assign pos_after_sec  = apply_move(pos_reg, sec_byte_w);
    assign pos_after_face = apply_move(pos_reg, face_byte_reg);

    always_comb
    begin
        state_next      = state_reg;
        job_next        = job_reg;
        pos_next        = pos_reg;
        sec_byte_next   = sec_byte_reg;
        sec_pend_next   = sec_pend_reg;
        face_byte_next  = face_byte_reg;
        face_pend_next  = face_pend_reg;
        above_next      = above_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        out_origin_next = out_origin_reg;
        out_pos_next    = out_pos_reg;
        out_last_next   = out_last_reg;
        q_pop           = 1'b0;

        // Drop the output word once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    job_next   = q_job;
                    state_next = B_SECT;
                end
            end
            B_SECT:
            begin
                if (job_reg.home)
                begin
                    if (cfg.rotator_enable)
                    begin
                        sec_byte_next = home_byte_w;
                        pos_next      = '0;
                        state_next    = B_EMIT_HOME;
                    end
                    else
                    begin
                        state_next = B_IDLE;
                    end
                end
                else
                begin
                    sec_pend_next = job_reg.change && cfg.rotator_enable;
                    if (job_reg.change)
                    begin
                        sec_byte_next = sec_byte_w;
                        pos_next      = pos_after_sec;
                    end
                    face_pend_next = 1'b0;
                    if (job_reg.face != '0)
                    begin
                        above_next = face_above;
                        quo_next   = dividend;
                        rem_next   = '0;
                        cnt_next   = '0;
                        state_next = B_DIV;
                    end
                    else
                    begin
                        state_next = sec_pend_next ? B_EMIT_SEC : B_IDLE;
                    end
                end
            end
            B_DIV:
            begin
                quo_next = div_q2;
                rem_next = div_r2s[5:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 3'(sfps_pkg::DIV_STEPS - 1))
                begin
                    state_next = B_FACE;
                end
            end
            B_FACE:
            begin
                face_byte_next = face_byte_w;
                face_pend_next = !face_dead && cfg.rotator_enable;
                if (sec_pend_reg)
                begin
                    state_next = B_EMIT_SEC;
                end
                else
                begin
                    state_next = face_pend_next ? B_EMIT_FACE : B_IDLE;
                end
            end
            B_EMIT_SEC:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = sec_byte_reg;
                    out_origin_next = sfps_pkg::ORIGIN_SECTOR;
                    out_pos_next    = pos_reg;
                    out_last_next   = !face_pend_reg;
                    state_next      = face_pend_reg ? B_EMIT_FACE : B_IDLE;
                end
            end
            B_EMIT_FACE:
            begin
                if (out_free)
                begin
                    pos_next        = pos_after_face;
                    out_valid_next  = 1'b1;
                    out_byte_next   = face_byte_reg;
                    out_origin_next = sfps_pkg::ORIGIN_FACE;
                    out_pos_next    = pos_after_face;
                    out_last_next   = 1'b1;
                    state_next      = B_IDLE;
                end
            end
            B_EMIT_HOME:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = sec_byte_reg;
                    out_origin_next = sfps_pkg::ORIGIN_HOME;
                    out_pos_next    = '0;
                    out_last_next   = 1'b1;
                    state_next      = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the work and output payload
    always_ff @(posedge clk)
    begin
        job_reg        <= job_next;
        sec_byte_reg   <= sec_byte_next;
        sec_pend_reg   <= sec_pend_next;
        face_byte_reg  <= face_byte_next;
        face_pend_reg  <= face_pend_next;
        above_reg      <= above_next;
        quo_reg        <= quo_next;
        rem_reg        <= rem_next;
        cnt_reg        <= cnt_next;
        out_byte_reg   <= out_byte_next;
        out_origin_reg <= out_origin_next;
        out_pos_reg    <= out_pos_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid      = out_valid_reg;
    assign step_byte      = out_byte_reg;
    assign move_origin    = out_origin_reg;
    assign position_after = out_pos_reg;
    assign last           = out_last_reg;

endmodule

@@ design/sound_and_face_pan_stepper.sv @@
// Pan stepper controller driven by four microphone levels and a face position.
// The front ranks the levels in its sort states and picks the sound sector
// (a home command skips the sort) and drops observations where every level
// is zero; the back turns each queued word into stepper words. With a face
// present, the back first divides the face offset by pixels per step, which
// retires two quotient bits per cycle, before it emits its words. A queue of
// QUEUE_DEPTH words lets the front accept the next observation while the back
// works. An input word yields zero, one or two output words; last marks the
// final one. Registers are written through the cfg port (ready always high)
// and should only be changed while no work is in flight.
module sound_and_face_pan_stepper #(
    parameter int QUEUE_DEPTH = sfps_pkg::QUEUE_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              command,
    input  logic [sfps_pkg::LEVEL_W-1:0]      level_mic0,
    input  logic [sfps_pkg::LEVEL_W-1:0]      level_mic1,
    input  logic [sfps_pkg::LEVEL_W-1:0]      level_mic2,
    input  logic [sfps_pkg::LEVEL_W-1:0]      level_mic3,
    input  logic [sfps_pkg::FACE_W-1:0]       face_column,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [sfps_pkg::BYTE_W-1:0]       step_byte,
    output logic [1:0]                        move_origin,
    output logic signed [sfps_pkg::POS_W-1:0] position_after,
    output logic                              last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [sfps_pkg::CAMW_W-1:0]       cfg_data
);

    sfps_pkg::cfg_t  cfg_reg;
    sfps_pkg::job_t  push_job, pop_job;
    logic            q_push, q_pop, q_full, q_empty;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.camera_width   <= sfps_pkg::CAMERA_WIDTH_RESET;
            cfg_reg.rotator_enable <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sfps_pkg::REG_CAMERA_WIDTH:   cfg_reg.camera_width   <= cfg_data;
                sfps_pkg::REG_ROTATOR_ENABLE: cfg_reg.rotator_enable <= cfg_data[0];
            endcase
        end
    end

    sfps_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .level_mic0  (level_mic0),
        .level_mic1  (level_mic1),
        .level_mic2  (level_mic2),
        .level_mic3  (level_mic3),
        .face_column (face_column),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_job       (push_job)
    );

    sfps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    sfps_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .q_empty        (q_empty),
        .q_job          (pop_job),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .step_byte      (step_byte),
        .move_origin    (move_origin),
        .position_after (position_after),
        .last           (last)
    );

endmodule

@@ design/sfps_checker.sv @@
module sfps_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [sfps_pkg::BYTE_W-1:0]       step_byte,
    input logic [1:0]                        move_origin,
    input logic signed [sfps_pkg::POS_W-1:0] position_after,
    input logic                              last
);

    // Hold a stalled output word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(step_byte)
            && $stable(move_origin) && $stable(position_after) && $stable(last))
        else $error("stalled output word changed");

    // Return home always lands at zero and ends the word group
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && move_origin == sfps_pkg::ORIGIN_HOME |-> position_after == '0 && last)
        else $error("home result not at zero or not last");

    // Face moves never come from the deadband and always close the group
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && move_origin == sfps_pkg::ORIGIN_FACE |->
            last && step_byte != 8'd0 && step_byte != 8'd1
            && step_byte != 8'd128 && step_byte != 8'd129)
        else $error("face result in deadband or not last");

    // Only a sector change can be followed by another word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> move_origin == sfps_pkg::ORIGIN_SECTOR)
        else $error("non-final result is not a sector change");

endmodule

bind sound_and_face_pan_stepper sfps_checker u_sfps_checker (.*);

@@ test/sound_and_face_pan_stepper_tb.sv @@
module sound_and_face_pan_stepper_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One observation as offered to the block, plus a flag that holds it back
    // until every pending stepper word has come out
    typedef struct packed {
        logic              command;
        logic [3:0][15:0]  level;
        logic [9:0]        face;
        logic              drain;
    } obs_t;

    // One stepper word as it should leave the block
    typedef struct packed {
        logic [7:0]         step;
        sfps_pkg::origin_t  origin;
        logic signed [15:0] pos;
        logic               tail;
    } move_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    obs_t        cur = '0;
    logic        command;
    logic [15:0] level_mic0;
    logic [15:0] level_mic1;
    logic [15:0] level_mic2;
    logic [15:0] level_mic3;
    logic [9:0]  face_column;

    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [7:0]         step_byte;
    logic [1:0]         move_origin;
    logic signed [15:0] position_after;
    logic               last;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [10:0] cfg_data = '0;

    // Stimulus still to be offered and stepper words still owed by the block
    obs_t  obs_queue [$];
    move_t moves_due [$];

    // Shadow of the block's registers and state
    logic [10:0]        cam_width = sfps_pkg::CAMERA_WIDTH_RESET;
    logic               rot_en = 1'b0;
    sfps_pkg::sector_t  head_sector = sfps_pkg::SECTOR_B;
    logic signed [15:0] head_pos = '0;

    // Handshake bookkeeping
    logic in_taken = 1'b0;
    logic out_taken = 1'b0;
    logic cfg_done = 1'b0;
    bit   tx_idle = 1'b0;
    bit   rx_idle = 1'b0;
    int   tx_gap = 0;
    int   rx_wait = 0;
    int   hold_left = 0;
    int   hold_mark = 30;
    int   holds_done = 0;

    int errors = 0;
    int fed_count = 0;
    int out_count = 0;
    int settings = 0;

    assign command     = cur.command;
    assign level_mic0  = cur.level[0];
    assign level_mic1  = cur.level[1];
    assign level_mic2  = cur.level[2];
    assign level_mic3  = cur.level[3];
    assign face_column = cur.face;

    sound_and_face_pan_stepper dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .level_mic0     (level_mic0),
        .level_mic1     (level_mic1),
        .level_mic2     (level_mic2),
        .level_mic3     (level_mic3),
        .face_column    (face_column),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .step_byte      (step_byte),
        .move_origin    (move_origin),
        .position_after (position_after),
        .last           (last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Apply one step to the position and clamp it to 16 signed bits
    function automatic logic signed [15:0] nudge(input int p, input logic [7:0] b);
        int q;
        if (b > 8'd128)
            q = p - (int'(b) - 127);
        else
            q = p + int'(b) + 1;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return q[15:0];
    endfunction

    // Append one observation to the stimulus list
    task automatic queue_obs(input obs_t o);
        obs_queue.insert(obs_queue.size(), o);
    endtask

    // Advance the shadow state by one observation and queue its stepper words
    task automatic compute_moves(input obs_t o);
        move_t             got [2];
        int                n;
        int                p;
        int                v;
        int                b;
        int                f;
        int                half;
        int                pps;
        int                t;
        int                lo;
        int                hi;
        int                ord [4];
        int                lv [4];
        sfps_pkg::sector_t nxt;
        n = 0;
        got[0] = '0;
        got[1] = '0;
        if (o.command)
        begin
            // Home: undo the whole position in one word
            if (rot_en)
            begin
                p = head_pos;
                b = (p > 0) ? 128 + p - 1 : -p - 1;
                head_pos = '0;
                got[n].step = b[7:0];
                got[n].origin = sfps_pkg::ORIGIN_HOME;
                got[n].pos = '0;
                n++;
            end
        end
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                lv[i] = int'(o.level[i]);
                ord[i] = i;
            end
            // Rank loudest first; a swap only on a strict less keeps tie order
            for (int i = 0; i < 4; i++)
                for (int j = i + 1; j < 4; j++)
                    if (lv[ord[i]] < lv[ord[j]])
                    begin
                        t = ord[i];
                        ord[i] = ord[j];
                        ord[j] = t;
                    end
            if (lv[ord[0]] != 0)
            begin
                lo = (ord[0] < ord[1]) ? ord[0] : ord[1];
                hi = (ord[0] < ord[1]) ? ord[1] : ord[0];
                nxt = head_sector;
                if (lo == 0 && hi == 1)
                    nxt = sfps_pkg::SECTOR_A;
                else if (lo == 1 && hi == 2)
                    nxt = sfps_pkg::SECTOR_B;
                else if (lo == 2 && hi == 3)
                    nxt = sfps_pkg::SECTOR_C;
                // Sector change: byte from the fixed turn table
                if (nxt != head_sector)
                begin
                    p = head_pos;
                    unique case (head_sector)
                        sfps_pkg::SECTOR_A:
                            v = (nxt == sfps_pkg::SECTOR_B) ? 128 + p :
                                (p >= 40) ? 208 + (p - 40) : 208 + (40 - p);
                        sfps_pkg::SECTOR_B:
                            v = (nxt == sfps_pkg::SECTOR_A) ? 40 - p : 168 + p;
                        default:
                            v = (nxt == sfps_pkg::SECTOR_A) ? 40 - p : -p;
                    endcase
                    head_pos = nudge(p, v[7:0]);
                    if (rot_en)
                    begin
                        got[n].step = v[7:0];
                        got[n].origin = sfps_pkg::ORIGIN_SECTOR;
                        got[n].pos = head_pos;
                        n++;
                    end
                end
                head_sector = nxt;
                // Face centering outside the deadband
                if (o.face != 0)
                begin
                    f = int'(o.face);
                    half = int'(cam_width) / 2;
                    pps = int'(cam_width) / 40;
                    if (pps == 0)
                        pps = 1;
                    if (f > half)
                        b = (f - half) / pps;
                    else
                        b = 128 + (half - f) / pps;
                    b = b & 255;
                    if (!(b < 2 || b == 128 || b == 129) && rot_en)
                    begin
                        head_pos = nudge(head_pos, b[7:0]);
                        got[n].step = b[7:0];
                        got[n].origin = sfps_pkg::ORIGIN_FACE;
                        got[n].pos = head_pos;
                        n++;
                    end
                end
            end
        end
        if (n > 0)
            got[n - 1].tail = 1'b1;
        for (int k = 0; k < n; k++)
            moves_due.insert(moves_due.size(), got[k]);
    endtask

    // Sample handshakes, predict accepted words and check returned ones
    always @(posedge clk)
    begin : watch
        move_t want;
        if (rst_n)
        begin
            in_taken <= in_valid && !in_stall;
            out_taken <= out_valid && !out_stall;
            cfg_done <= cfg_valid && cfg_ready;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == sfps_pkg::REG_CAMERA_WIDTH)
                    cam_width = cfg_data;
                else
                    rot_en = cfg_data[0];
            end
            if (out_valid && !out_stall)
            begin
                out_count++;
                if (moves_due.size() == 0)
                begin
                    $error("unexpected stepper word: step_byte %0d, move_origin %0d",
                           step_byte, move_origin);
                    errors++;
                end
                else
                begin
                    want = moves_due.pop_front();
                    if (step_byte !== want.step)
                    begin
                        $error("step_byte: expected %0d, got %0d", want.step, step_byte);
                        errors++;
                    end
                    if (move_origin !== want.origin)
                    begin
                        $error("move_origin: expected %0d, got %0d", want.origin, move_origin);
                        errors++;
                    end
                    if (position_after !== want.pos)
                    begin
                        $error("position_after: expected %0d, got %0d",
                               want.pos, position_after);
                        errors++;
                    end
                    if (last !== want.tail)
                    begin
                        $error("last: expected %0d, got %0d", want.tail, last);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                fed_count++;
                compute_moves(cur);
            end
        end
    end

    // Feed observations from the queue, with a random gap after each word when tx_idle is set
    always @(negedge clk)
    begin : feed
        logic nxt_valid;
        if (rst_n)
        begin
            nxt_valid = in_valid;
            if (in_valid && in_taken)
            begin
                nxt_valid = 1'b0;
                tx_gap = tx_idle ? int'($urandom_range(0, 7)) : 0;
            end
            if (!nxt_valid)
            begin
                if (tx_gap > 0)
                    tx_gap--;
                else if (obs_queue.size() > 0 &&
                         !(obs_queue[0].drain && moves_due.size() > 0))
                begin
                    cur <= obs_queue.pop_front();
                    nxt_valid = 1'b1;
                end
            end
            in_valid <= nxt_valid;
        end
    end

    // Stall the result side: a random wait after each word when rx_idle is set, and two long holds
    always @(negedge clk)
    begin : sink
        if (rst_n)
        begin
            if (out_count >= hold_mark && hold_left == 0 && holds_done < 2)
            begin
                hold_left = 120;
                holds_done++;
                hold_mark += 200;
            end
            if (hold_left > 0)
                hold_left--;
            if (out_taken)
                rx_wait = rx_idle ? int'($urandom_range(0, 7)) : 0;
            else if (rx_wait > 0)
                rx_wait--;
            out_stall <= (hold_left > 0) || (rx_wait > 0);
        end
    end

    function automatic obs_t make_obs(input logic cmd, input logic [15:0] l0,
                                      input logic [15:0] l1, input logic [15:0] l2,
                                      input logic [15:0] l3, input logic [9:0] f);
        obs_t o;
        o.command = cmd;
        o.level[0] = l0;
        o.level[1] = l1;
        o.level[2] = l2;
        o.level[3] = l3;
        o.face = f;
        o.drain = 1'b0;
        return o;
    endfunction

    // General observation: mostly a clear loudest pair, plus homes, silence and ties
    function automatic obs_t draw_obs();
        obs_t o;
        int   kind;
        int   sel;
        int   half;
        int   pps;
        int   t;
        int   pair_lo [6] = '{0, 1, 2, 0, 0, 1};
        int   pair_hi [6] = '{1, 2, 3, 2, 3, 3};
        o = '0;
        for (int i = 0; i < 4; i++)
            o.level[i] = 16'($urandom_range(0, 65535));
        o.face = 10'($urandom_range(0, 1023));
        kind = int'($urandom_range(0, 99));
        if (kind < 8)
            o.command = 1'b1;
        else if (kind < 14)
            o.level = '0;
        else if (kind < 32 && kind >= 24)
        begin
            for (int i = 0; i < 4; i++)
                o.level[i] = 16'($urandom_range(0, 3));
        end
        else if (kind >= 32)
        begin
            sel = int'($urandom_range(0, 8));
            if (sel > 5)
                sel -= 6;
            for (int i = 0; i < 4; i++)
                o.level[i] = (i == pair_lo[sel] || i == pair_hi[sel]) ?
                             16'($urandom_range(256, 65535)) : 16'($urandom_range(0, 255));
        end
        sel = int'($urandom_range(0, 9));
        if (sel < 2)
            o.face = '0;
        else if (sel < 5)
        begin
            // Land near the center to work the deadband edges
            half = int'(cam_width) / 2;
            pps = int'(cam_width) / 40;
            if (pps == 0)
                pps = 1;
            t = half - 3 * pps + int'($urandom_range(0, 6 * pps));
            if (t < 0)
                t = 0;
            if (t > 1023)
                t = 1023;
            o.face = t[9:0];
        end
        return o;
    endfunction

    // Steady rightward push at the widest step so the position saturates
    function automatic obs_t draw_push_obs();
        obs_t o;
        if ($urandom_range(0, 99) < 92)
        begin
            o = '0;
            o.level[0] = 16'($urandom_range(256, 65535));
            o.level[1] = 16'($urandom_range(0, 255));
            o.level[2] = 16'($urandom_range(0, 255));
            o.level[3] = 16'($urandom_range(256, 65535));
            o.face = 10'($urandom_range(0, 3) * 256 + 127);
        end
        else
        begin
            o = draw_obs();
            o.command = 1'b0;
        end
        return o;
    endfunction

    task automatic write_reg(input logic idx, input int val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[10:0];
        @(negedge clk);
        while (!cfg_done)
            @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until nothing is owed, then let any silent words drain out
    task automatic settle();
        while (obs_queue.size() > 0 || in_valid || moves_due.size() > 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
    endtask

    task automatic run_phase(input int width, input logic enable, input int count,
                             input bit push, input bit tx_on, input bit rx_on);
        obs_t o;
        settle();
        tx_idle = tx_on;
        rx_idle = rx_on;
        write_reg(sfps_pkg::REG_CAMERA_WIDTH, width);
        write_reg(sfps_pkg::REG_ROTATOR_ENABLE, int'(enable));
        settings++;
        @(posedge clk);
        for (int i = 0; i < count; i++)
        begin
            o = push ? draw_push_obs() : draw_obs();
            if (i == count / 2)
                o.drain = 1'b1;
            if (push && i == count - 1)
                o.command = 1'b1;
            queue_obs(o);
        end
    endtask

    initial
    begin
        #500000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int spin;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: silence, every sector turn, deadband edges, ties, homes
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        write_reg(sfps_pkg::REG_CAMERA_WIDTH, 640);
        write_reg(sfps_pkg::REG_ROTATOR_ENABLE, 1);
        settings++;
        @(posedge clk);
        queue_obs(make_obs(1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 10'd500));
        queue_obs(make_obs(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 10'd0));
        queue_obs(make_obs(1'b0, 16'd900, 16'd800, 16'd10, 16'd5, 10'd0));
        queue_obs(make_obs(1'b0, 16'd10, 16'd800, 16'd900, 16'd5, 10'd0));
        queue_obs(make_obs(1'b0, 16'd5, 16'd10, 16'd800, 16'd900, 10'd0));
        queue_obs(make_obs(1'b0, 16'd900, 16'd800, 16'd10, 16'd5, 10'd0));
        queue_obs(make_obs(1'b0, 16'd5, 16'd10, 16'd800, 16'd900, 10'd0));
        queue_obs(make_obs(1'b0, 16'd10, 16'd800, 16'd900, 16'd5, 10'd0));
        queue_obs(make_obs(1'b0, 16'd900, 16'd10, 16'd800, 16'd5, 10'd1023));
        queue_obs(make_obs(1'b0, 16'd900, 16'd10, 16'd5, 16'd800, 10'd1));
        queue_obs(make_obs(1'b0, 16'd10, 16'd900, 16'd5, 16'd800, 10'd320));
        queue_obs(make_obs(1'b0, 16'd10, 16'd900, 16'd5, 16'd800, 10'd321));
        queue_obs(make_obs(1'b0, 16'd10, 16'd900, 16'd5, 16'd800, 10'd352));
        queue_obs(make_obs(1'b0, 16'd10, 16'd900, 16'd5, 16'd800, 10'd304));
        queue_obs(make_obs(1'b0, 16'd10, 16'd900, 16'd5, 16'd800, 10'd288));
        queue_obs(make_obs(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd700));
        queue_obs(make_obs(1'b0, 16'd7, 16'd7, 16'd3, 16'd3, 10'd0));
        queue_obs(make_obs(1'b0, 16'd0, 16'd0, 16'd0, 16'd1, 10'd1023));
        queue_obs(make_obs(1'b1, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 10'd1023));
        queue_obs(make_obs(1'b0, 16'd0, 16'd0, 16'd800, 16'd900, 10'd0));
        queue_obs(make_obs(1'b0, 16'hFFFF, 16'h0000, 16'hFFFE, 16'h0001, 10'd1023));
        queue_obs(make_obs(1'b0, 16'd10, 16'd900, 16'd5, 16'd800, 10'd1));
        queue_obs(make_obs(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'h3FF));

        // Random phases across widths, rotator off, tiny and full-scale widths
        run_phase(640, 1'b1, 40, 1'b0, 1'b1, 1'b1);
        run_phase(320, 1'b1, 25, 1'b0, 1'b0, 1'b0);
        run_phase(1024, 1'b0, 25, 1'b0, 1'b1, 1'b1);
        run_phase(39, 1'b1, 25, 1'b0, 1'b1, 1'b0);
        run_phase(0, 1'b1, 300, 1'b1, 1'b1, 1'b1);
        run_phase(2047, 1'b1, 25, 1'b0, 1'b0, 1'b1);
        run_phase(800, 1'b1, 25, 1'b0, 1'b1, 1'b1);

        // Drain everything still owed, with a bound
        spin = 0;
        while ((obs_queue.size() > 0 || in_valid || moves_due.size() > 0) && spin < 20000)
        begin
            @(posedge clk);
            spin++;
        end
        repeat (64) @(posedge clk);
        if (moves_due.size() > 0)
        begin
            $error("%0d stepper words never arrived", moves_due.size());
            errors++;
        end

        $display("Covered %0d observations over %0d register settings; %0d words checked",
                 fed_count, settings, out_count);
        $display("Included silence, level ties, all sector turns, deadband edges, homes, clamping");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
